[sv/assert_macros.svh]
// Assertion macros shared by the tile rotation scatter RTL.
// No dependencies; define SYNTH to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define TRS_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("assertion failed");
// Expression must never be true at a clock edge outside reset.
`define TRS_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error("forbidden condition seen");
`else
`define TRS_ASSERT(lbl, clk, rstn, prop)
`define TRS_NEVER(lbl, clk, rstn, expr)
`endif
`endif

[sv/trs_pkg.sv]
`timescale 1ns / 1ps
// Types and constants shared by the tile rotation scatter modules.
// No dependencies.
package trs_pkg;

	localparam int COORD_W       = 12;
	localparam int PIX_W         = 32;
	localparam int IDX_W         = 14;
	localparam int DIM_W         = 13;
	localparam int TBITS_W       = 3;
	localparam int TILE_W        = 26;
	localparam int MAX_TILE_BITS = 5;

	typedef enum logic [1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_CUBE_BITS    = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		DIR_NONE  = 2'd0,
		DIR_RIGHT = 2'd1,
		DIR_DOWN  = 2'd2,
		DIR_LEFT  = 2'd3
	} dir_t;

	localparam logic OP_MAP_WRITE = 1'b0;
	localparam logic OP_PIXEL     = 1'b1;

	// Per-stage advance enables.
	typedef struct packed {
		logic en1;
		logic en2;
		logic en3;
	} stage_en_t;

	// Item leaving the front end, tile number resolved.
	typedef struct packed {
		logic                opcode;
		logic [COORD_W-1:0]  pos_x;
		logic [COORD_W-1:0]  pos_y;
		logic [PIX_W-1:0]    pixel;
		logic [IDX_W-1:0]    map_index;
		dir_t                direction;
		logic [TBITS_W-1:0]  tile_bits;
		logic                in_range;
		logic [TILE_W-1:0]   tile;
	} front_item_t;

	// Pixel with its tile direction read back from the map.
	typedef struct packed {
		logic [COORD_W-1:0]  pos_x;
		logic [COORD_W-1:0]  pos_y;
		logic [PIX_W-1:0]    pixel;
		logic [TBITS_W-1:0]  tile_bits;
		dir_t                direction;
	} rot_item_t;

endpackage

[sv/trs_front.sv]
`timescale 1ns / 1ps
// Front end: tile coordinate split, whole-tile check and tile number multiply.
// Depends on trs_pkg.
module trs_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  trs_pkg::stage_en_t          en,
	input  logic                        in_valid,
	input  logic                        opcode,
	input  logic [trs_pkg::COORD_W-1:0] pos_x,
	input  logic [trs_pkg::COORD_W-1:0] pos_y,
	input  logic [trs_pkg::PIX_W-1:0]   pixel_in,
	input  logic [trs_pkg::IDX_W-1:0]   map_index,
	input  trs_pkg::dir_t               direction,
	input  logic [trs_pkg::DIM_W-1:0]   frame_width,
	input  logic [trs_pkg::DIM_W-1:0]   frame_height,
	input  logic [trs_pkg::TBITS_W-1:0] cube_bits,
	output logic                        v1,
	output logic                        v2,
	output trs_pkg::front_item_t        item
);

	logic [trs_pkg::TBITS_W-1:0] tb;
	logic [trs_pkg::DIM_W-1:0]   cols;
	logic [trs_pkg::DIM_W-1:0]   rows;
	logic [trs_pkg::COORD_W-1:0] tx;
	logic [trs_pkg::COORD_W-1:0] ty;
	logic                        in_range;

	logic                        v_s1;
	logic                        op_s1;
	logic [trs_pkg::COORD_W-1:0] px_s1;
	logic [trs_pkg::COORD_W-1:0] py_s1;
	logic [trs_pkg::PIX_W-1:0]   pix_s1;
	logic [trs_pkg::IDX_W-1:0]   idx_s1;
	trs_pkg::dir_t               dir_s1;
	logic [trs_pkg::TBITS_W-1:0] tb_s1;
	logic [trs_pkg::COORD_W-1:0] tx_s1;
	logic [trs_pkg::COORD_W-1:0] ty_s1;
	logic [trs_pkg::DIM_W-1:0]   cols_s1;
	logic                        rng_s1;

	logic                        v_s2;
	trs_pkg::front_item_t        item_s2;

	// Saturate the tile size, then split coordinates into tile and offset.
	always_comb begin
		if (cube_bits > trs_pkg::TBITS_W'(trs_pkg::MAX_TILE_BITS)) begin
			tb = trs_pkg::TBITS_W'(trs_pkg::MAX_TILE_BITS);
		end else begin
			tb = cube_bits;
		end
		cols     = frame_width >> tb;
		rows     = frame_height >> tb;
		tx       = pos_x >> tb;
		ty       = pos_y >> tb;
		in_range = ({1'b0, tx} < cols) && ({1'b0, ty} < rows);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en.en1) begin
				v_s1 <= in_valid;
			end
			if (en.en2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.en1 && in_valid) begin
			op_s1   <= opcode;
			px_s1   <= pos_x;
			py_s1   <= pos_y;
			pix_s1  <= pixel_in;
			idx_s1  <= map_index;
			dir_s1  <= direction;
			tb_s1   <= tb;
			tx_s1   <= tx;
			ty_s1   <= ty;
			cols_s1 <= cols;
			rng_s1  <= in_range;
		end
	end

	// Tile number in raster order: one multiply and add.
	always_ff @(posedge clk) begin
		if (en.en2 && v_s1) begin
			item_s2.opcode    <= op_s1;
			item_s2.pos_x     <= px_s1;
			item_s2.pos_y     <= py_s1;
			item_s2.pixel     <= pix_s1;
			item_s2.map_index <= idx_s1;
			item_s2.direction <= dir_s1;
			item_s2.tile_bits <= tb_s1;
			item_s2.in_range  <= rng_s1;
			item_s2.tile      <= trs_pkg::TILE_W'(ty_s1) * trs_pkg::TILE_W'(cols_s1)
				+ trs_pkg::TILE_W'(tx_s1);
		end
	end

	assign v1   = v_s1;
	assign v2   = v_s2;
	assign item = item_s2;

endmodule

[sv/trs_map.sv]
`timescale 1ns / 1ps
// Tile direction memory: map writes and pixel lookups in stream order.
// Depends on trs_pkg.
module trs_map #(
	parameter int MAP_DEPTH = 16384
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  trs_pkg::stage_en_t   en,
	input  logic                 in_valid,
	input  trs_pkg::front_item_t item,
	output logic                 v3,
	output trs_pkg::rot_item_t   out_item
);

	localparam int AW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

	logic [1:0]         mem [MAP_DEPTH];
	logic [1:0]         rd_s3;
	logic               v_s3;
	trs_pkg::rot_item_t hold_s3;
	logic               wr_en;
	logic               keep;

	// Writes and reads both happen as an item leaves stage 2, so a pixel
	// after a map write always sees it and no forwarding is needed.
	assign wr_en = en.en3 && in_valid && (item.opcode == trs_pkg::OP_MAP_WRITE)
		&& (32'(item.map_index) < MAP_DEPTH);
	assign keep  = in_valid && (item.opcode == trs_pkg::OP_PIXEL) && item.in_range
		&& (32'(item.tile) < MAP_DEPTH);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[AW'(item.map_index)] <= item.direction;
		end
		if (en.en3) begin
			rd_s3 <= mem[AW'(item.tile)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en.en3) begin
			v_s3 <= keep;
		end
	end

	always_ff @(posedge clk) begin
		if (en.en3 && keep) begin
			hold_s3.pos_x     <= item.pos_x;
			hold_s3.pos_y     <= item.pos_y;
			hold_s3.pixel     <= item.pixel;
			hold_s3.tile_bits <= item.tile_bits;
			hold_s3.direction <= trs_pkg::DIR_NONE;
		end
	end

	always_comb begin
		out_item           = hold_s3;
		out_item.direction = trs_pkg::dir_t'(rd_s3);
	end

	assign v3 = v_s3;

endmodule

[sv/trs_rotate.sv]
`timescale 1ns / 1ps
// Rotation of the in-tile offset and the result output register.
// Depends on trs_pkg.
module trs_rotate (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  logic                        in_valid,
	input  trs_pkg::rot_item_t          item,
	output logic                        out_valid,
	output logic [trs_pkg::COORD_W-1:0] dest_x,
	output logic [trs_pkg::COORD_W-1:0] dest_y,
	output logic [trs_pkg::PIX_W-1:0]   pixel_out
);

	logic [trs_pkg::COORD_W-1:0] mask;
	logic [trs_pkg::COORD_W-1:0] lx;
	logic [trs_pkg::COORD_W-1:0] ly;
	logic [trs_pkg::COORD_W-1:0] nx;
	logic [trs_pkg::COORD_W-1:0] ny;
	logic                        v_q;
	logic [trs_pkg::COORD_W-1:0] dx_q;
	logic [trs_pkg::COORD_W-1:0] dy_q;
	logic [trs_pkg::PIX_W-1:0]   pix_q;

	always_comb begin
		mask = (trs_pkg::COORD_W'(1) << item.tile_bits) - trs_pkg::COORD_W'(1);
		lx   = item.pos_x & mask;
		ly   = item.pos_y & mask;
		case (item.direction)
			trs_pkg::DIR_RIGHT: begin
				nx = ly;
				ny = mask - lx;
			end
			trs_pkg::DIR_DOWN: begin
				nx = mask - lx;
				ny = mask - ly;
			end
			trs_pkg::DIR_LEFT: begin
				nx = mask - ly;
				ny = lx;
			end
			default: begin
				nx = lx;
				ny = ly;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (load) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			dx_q  <= (item.pos_x & ~mask) + nx;
			dy_q  <= (item.pos_y & ~mask) + ny;
			pix_q <= item.pixel;
		end
	end

	assign out_valid = v_q;
	assign dest_x    = dx_q;
	assign dest_y    = dy_q;
	assign pixel_out = pix_q;

endmodule

[sv/tile_rotation_scatter_top.sv]
`timescale 1ns / 1ps
// Tile rotation scatter, top level: channels, configuration and stall chain.
// Depends on trs_pkg, trs_front, trs_map, trs_rotate and assert_macros.svh.
//
// Usage:
//  - The slave stream carries map writes (tuser = 0) and source pixels (tuser = 1).
//    A map write stores a 2-bit rotation for one tile; a pixel beat returns its
//    destination coordinates and unchanged value on the master stream, or
//    nothing when it lies outside every whole tile of the frame or beyond the map.
//  - Configuration beats (frame width, frame height, tile size) are taken every
//    cycle; write them only while the pipeline is empty.
//  - Path: the edge that accepts a pixel beat loads the first front stage; the
//    second front stage, the map read and the output register follow, and the
//    output register drives the master stream.
//  - Throughput: one beat per cycle while the receiver does not stall, map writes
//    and pixels alike; the map has a single write and a single read port, both
//    used in the same stage, so a pixel always sees every earlier map write.
//  - Reset clears the pipeline valids and loads frame 640 x 480, 16-pixel tiles.
//    The map is not cleared: load every tile entry before sending pixels to it.
//  - When the receiver stalls, each stage holds only if the one after it is
//    full, so the input keeps taking beats until the pipeline fills.
`include "assert_macros.svh"

module tile_rotation_scatter_top #(
	parameter int MAP_DEPTH = 16384
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data,
	// source stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata: pos_x[11:0], pos_y[23:12], pixel_in[55:24], map_index[69:56],
	//        direction[71:70]
	input  logic [71:0] s_axis_tdata,
	// tuser: opcode[0]
	input  logic [0:0]  s_axis_tuser,
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// tdata: dest_x[11:0], dest_y[23:12], pixel_out[55:24]
	output logic [55:0] m_axis_tdata
);

	logic [trs_pkg::DIM_W-1:0]   frame_width_q;
	logic [trs_pkg::DIM_W-1:0]   frame_height_q;
	logic [trs_pkg::TBITS_W-1:0] cube_bits_q;

	trs_pkg::stage_en_t          en;
	trs_pkg::front_item_t        front_item;
	trs_pkg::rot_item_t          rot_item;
	logic                        v1;
	logic                        v2;
	logic                        v3;
	logic                        out_en;
	logic [trs_pkg::COORD_W-1:0] dest_x;
	logic [trs_pkg::COORD_W-1:0] dest_y;
	logic [trs_pkg::PIX_W-1:0]   pixel_out;

	// Configuration registers; indexes past the list are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= 13'd640;
			frame_height_q <= 13'd480;
			cube_bits_q    <= 3'd4;
		end else if (cfg_valid) begin
			case (trs_pkg::cfg_reg_t'(cfg_index))
				trs_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				trs_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				trs_pkg::REG_CUBE_BITS:    cube_bits_q    <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// Stall chain: a stage advances when the stage after it is empty or moving.
	assign out_en        = !m_axis_tvalid || m_axis_tready;
	assign en.en3        = !v3 || out_en;
	assign en.en2        = !v2 || en.en3;
	assign en.en1        = !v1 || en.en2;
	assign s_axis_tready = en.en1;

	trs_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.in_valid     (s_axis_tvalid),
		.opcode       (s_axis_tuser[0]),
		.pos_x        (s_axis_tdata[11:0]),
		.pos_y        (s_axis_tdata[23:12]),
		.pixel_in     (s_axis_tdata[55:24]),
		.map_index    (s_axis_tdata[69:56]),
		.direction    (trs_pkg::dir_t'(s_axis_tdata[71:70])),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.cube_bits    (cube_bits_q),
		.v1           (v1),
		.v2           (v2),
		.item         (front_item)
	);

	trs_map #(
		.MAP_DEPTH (MAP_DEPTH)
	) u_map (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v2),
		.item     (front_item),
		.v3       (v3),
		.out_item (rot_item)
	);

	trs_rotate u_rotate (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (out_en),
		.in_valid  (v3),
		.item      (rot_item),
		.out_valid (m_axis_tvalid),
		.dest_x    (dest_x),
		.dest_y    (dest_y),
		.pixel_out (pixel_out)
	);

	assign m_axis_tdata = {pixel_out, dest_y, dest_x};

	// A result only ever comes from an occupied map stage.
	`TRS_ASSERT(a_out_from_s3, clk, arst_n, $rose(m_axis_tvalid) |-> $past(v3))
	// An empty output register never blocks the input.
	`TRS_NEVER(a_ready_when_empty, clk, arst_n, !m_axis_tvalid && !s_axis_tready)
	// After a result is taken, a new one follows only from the map stage.
	`TRS_ASSERT(a_refill_from_s3, clk, arst_n,
		(m_axis_tvalid && m_axis_tready) |=> (!m_axis_tvalid || $past(v3)))
	// A full pipeline with a stalled receiver takes no beat.
	`TRS_NEVER(a_full_stall, clk, arst_n,
		v1 && v2 && v3 && m_axis_tvalid && !m_axis_tready && s_axis_tready)

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for tile_rotation_scatter_top: a directed table, then random phases.
// Depends on trs_pkg and the RTL; an in-file scatter predictor produces the expected beats.
module tb_top;

	localparam int MAP_DEPTH    = 16384;
	localparam int DRAIN_CYCLES = 12;
	localparam int CYCLE_LIMIT  = 1000000;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [12:0] cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	// tdata: pos_x[11:0], pos_y[23:12], pixel_in[55:24], map_index[69:56], direction[71:70]
	logic [71:0] s_axis_tdata;
	// tuser: opcode[0]
	logic [0:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	// tdata: dest_x[11:0], dest_y[23:12], pixel_out[55:24]
	logic [55:0] m_axis_tdata;

	typedef struct {
		logic           op;
		bit   [11:0]    pos_x;
		bit   [11:0]    pos_y;
		bit   [31:0]    pixel;
		bit   [13:0]    map_index;
		trs_pkg::dir_t  direction;
	} beat_t;

	typedef struct {
		bit [11:0] dest_x;
		bit [11:0] dest_y;
		bit [31:0] pixel;
	} dest_t;

	typedef enum {ROW_BEAT, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t         kind;
		trs_pkg::cfg_reg_t reg_sel;
		bit [12:0]         reg_val;
		beat_t             beat;
		bit                fixed_exp;
		bit                exp_hit;
		bit [11:0]         exp_x;
		bit [11:0]         exp_y;
	} stim_row_t;

	// Predictor state: configuration and the tile direction store.
	bit [12:0]     frame_w  = 13'd640;
	bit [12:0]     frame_h  = 13'd480;
	bit [2:0]      cube_sel = 3'd4;
	trs_pkg::dir_t tile_dir    [MAP_DEPTH];
	bit            tile_loaded [MAP_DEPTH];

	dest_t     dest_q[$];
	stim_row_t rows[$];
	int        errors = 0;
	int        cycle_count;
	int        tx_steady_left;
	int        hold_req_cnt;

	tile_rotation_scatter_top #(
		.MAP_DEPTH(MAP_DEPTH)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Effective tile shift: the register saturates at the largest tile size.
	function automatic int tile_shift();
		int s;
		s = int'(cube_sel);
		if (s > trs_pkg::MAX_TILE_BITS)
			s = trs_pkg::MAX_TILE_BITS;
		return s;
	endfunction

	// Tile number a pixel reads from the store, or -1 when it lies outside every
	// whole tile of the frame or beyond the store and so reads nothing.
	function automatic int map_slot(input bit [11:0] x, input bit [11:0] y);
		int tb, cols, rows_n, tx, ty;
		tb     = tile_shift();
		cols   = int'(frame_w) >> tb;
		rows_n = int'(frame_h) >> tb;
		tx     = int'(x) >> tb;
		ty     = int'(y) >> tb;
		if (tx >= cols || ty >= rows_n)
			return -1;
		if (ty * cols + tx >= MAP_DEPTH)
			return -1;
		return ty * cols + tx;
	endfunction

	// Apply one beat to the predictor; returns 1 when it yields a destination.
	function automatic bit scatter_step(input beat_t b, output dest_t d);
		int slot, tb, side, lx, ly, nx, ny;
		d = '{default: 0};
		if (b.op == trs_pkg::OP_MAP_WRITE) begin
			if (int'(b.map_index) < MAP_DEPTH) begin
				tile_dir[b.map_index]    = b.direction;
				tile_loaded[b.map_index] = 1'b1;
			end
			return 1'b0;
		end
		slot = map_slot(b.pos_x, b.pos_y);
		if (slot < 0)
			return 1'b0;
		tb   = tile_shift();
		side = 1 << tb;
		lx   = int'(b.pos_x) & (side - 1);
		ly   = int'(b.pos_y) & (side - 1);
		case (tile_dir[slot])
			trs_pkg::DIR_RIGHT: begin
				nx = ly;
				ny = side - 1 - lx;
			end
			trs_pkg::DIR_DOWN: begin
				nx = side - 1 - lx;
				ny = side - 1 - ly;
			end
			trs_pkg::DIR_LEFT: begin
				nx = side - 1 - ly;
				ny = lx;
			end
			default: begin
				nx = lx;
				ny = ly;
			end
		endcase
		d.dest_x = 12'(((int'(b.pos_x) >> tb) << tb) + nx);
		d.dest_y = 12'(((int'(b.pos_y) >> tb) << tb) + ny);
		d.pixel  = b.pixel;
		return 1'b1;
	endfunction

	// Gap length: mostly none or short, now and then long.
	function automatic int idle_len();
		int r;
		r = int'($urandom_range(0, 99));
		if (r < 60)
			return 0;
		if (r < 88)
			return int'($urandom_range(1, 3));
		if (r < 97)
			return int'($urandom_range(4, 12));
		return int'($urandom_range(20, 40));
	endfunction

	function automatic beat_t map_beat(input int idx, input trs_pkg::dir_t d);
		beat_t b;
		b.op        = trs_pkg::OP_MAP_WRITE;
		b.pos_x     = 12'($urandom);
		b.pos_y     = 12'($urandom);
		b.pixel     = $urandom;
		b.map_index = 14'(idx);
		b.direction = d;
		return b;
	endfunction

	function automatic stim_row_t blank_row();
		stim_row_t r;
		r.kind           = ROW_BEAT;
		r.reg_sel        = trs_pkg::REG_FRAME_WIDTH;
		r.reg_val        = 13'd0;
		r.beat.op        = trs_pkg::OP_PIXEL;
		r.beat.pos_x     = 12'd0;
		r.beat.pos_y     = 12'd0;
		r.beat.pixel     = 32'd0;
		r.beat.map_index = 14'd0;
		r.beat.direction = trs_pkg::DIR_NONE;
		r.fixed_exp      = 1'b0;
		r.exp_hit        = 1'b0;
		r.exp_x          = 12'd0;
		r.exp_y          = 12'd0;
		return r;
	endfunction

	task automatic add_map(input int idx, input trs_pkg::dir_t d);
		stim_row_t r;
		r           = blank_row();
		r.kind      = ROW_BEAT;
		r.beat      = map_beat(idx, d);
		r.fixed_exp = 1'b1;
		rows.push_back(r);
	endtask

	task automatic add_pixel(input int x, input int y, input bit [31:0] pix,
			input bit fixed, input bit hit, input int ex, input int ey);
		stim_row_t r;
		r                = blank_row();
		r.kind           = ROW_BEAT;
		r.beat.op        = trs_pkg::OP_PIXEL;
		r.beat.pos_x     = 12'(x);
		r.beat.pos_y     = 12'(y);
		r.beat.pixel     = pix;
		r.beat.map_index = 14'($urandom);
		r.beat.direction = trs_pkg::dir_t'($urandom_range(0, 3));
		r.fixed_exp      = fixed;
		r.exp_hit        = hit;
		r.exp_x          = 12'(ex);
		r.exp_y          = 12'(ey);
		rows.push_back(r);
	endtask

	task automatic add_cfg(input trs_pkg::cfg_reg_t sel, input int val);
		stim_row_t r;
		r         = blank_row();
		r.kind    = ROW_CFG;
		r.reg_sel = sel;
		r.reg_val = 13'(val);
		rows.push_back(r);
	endtask

	// Offer one beat and hold it until taken; predict at the accepting edge.
	// A fixed expectation replaces the predictor's result, which still
	// updates the store.
	task automatic send_beat(input beat_t b, input bit fixed, input bit hit,
			input bit [11:0] ex, input bit [11:0] ey);
		dest_t d;
		bit    model_hit;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {b.direction, b.map_index, b.pixel, b.pos_y, b.pos_x};
		s_axis_tuser  <= b.op;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		model_hit = scatter_step(b, d);
		if (fixed) begin
			if (hit) begin
				d.dest_x = ex;
				d.dest_y = ey;
				d.pixel  = b.pixel;
				dest_q.push_back(d);
			end
		end else if (model_hit) begin
			dest_q.push_back(d);
		end
	endtask

	task automatic sender_pause();
		int n;
		if (tx_steady_left > 0) begin
			tx_steady_left--;
			return;
		end
		if ($urandom_range(0, 99) < 2) begin
			tx_steady_left = int'($urandom_range(20, 80));
			return;
		end
		n = idle_len();
		if (n > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Drop the source valid, let every expected beat arrive, then give the
	// pipeline time to flush beats that produce nothing.
	task automatic drain_pipe();
		s_axis_tvalid <= 1'b0;
		while (dest_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input trs_pkg::cfg_reg_t sel, input bit [12:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (sel)
			trs_pkg::REG_FRAME_WIDTH:  frame_w  = val;
			trs_pkg::REG_FRAME_HEIGHT: frame_h  = val;
			trs_pkg::REG_CUBE_BITS:    cube_sel = val[2:0];
			default: ;
		endcase
	endtask

	task automatic set_frame(input int w, input int h, input int cb);
		drain_pipe();
		write_reg(trs_pkg::REG_FRAME_WIDTH, 13'(w));
		write_reg(trs_pkg::REG_FRAME_HEIGHT, 13'(h));
		write_reg(trs_pkg::REG_CUBE_BITS, 13'(cb));
		cfg_valid <= 1'b0;
	endtask

	// Random pixel: mostly inside whole tiles (often a small corner region so
	// tiles are revisited), some anywhere, some in the partial edge tiles.
	function automatic beat_t random_pixel();
		beat_t b;
		int    tb, cols, rows_n, lim_x, lim_y, tx, ty, r;
		b.op        = trs_pkg::OP_PIXEL;
		b.pixel     = $urandom;
		b.map_index = 14'($urandom);
		b.direction = trs_pkg::dir_t'($urandom_range(0, 3));
		b.pos_x     = 12'($urandom);
		b.pos_y     = 12'($urandom);
		tb     = tile_shift();
		cols   = int'(frame_w) >> tb;
		rows_n = int'(frame_h) >> tb;
		lim_x  = (cols < 4) ? cols : 4;
		lim_y  = (rows_n < 4) ? rows_n : 4;
		r      = int'($urandom_range(0, 99));
		if (r < 70 && cols > 0 && rows_n > 0) begin
			tx = $urandom_range(0, 1) ? int'($urandom_range(0, lim_x - 1))
				: int'($urandom_range(0, cols - 1));
			ty = $urandom_range(0, 1) ? int'($urandom_range(0, lim_y - 1))
				: int'($urandom_range(0, rows_n - 1));
			b.pos_x = 12'((tx << tb) + int'($urandom_range(0, (1 << tb) - 1)));
			b.pos_y = 12'((ty << tb) + int'($urandom_range(0, (1 << tb) - 1)));
		end else if (r >= 85) begin
			if ($urandom_range(0, 1) && (cols << tb) <= 4095)
				b.pos_x = 12'($urandom_range(cols << tb, 4095));
			else if ((rows_n << tb) <= 4095)
				b.pos_y = 12'($urandom_range(rows_n << tb, 4095));
		end
		return b;
	endfunction

	// Map write used as noise: anywhere in the store, or re-pointing a tile
	// of the corner region that pixels keep visiting.
	function automatic beat_t random_map();
		int tb, cols, rows_n, slot;
		tb     = tile_shift();
		cols   = int'(frame_w) >> tb;
		rows_n = int'(frame_h) >> tb;
		slot   = int'($urandom_range(0, MAP_DEPTH - 1));
		if ($urandom_range(0, 1) && cols > 0 && rows_n > 0) begin
			slot = int'($urandom_range(0, (rows_n < 4 ? rows_n : 4) - 1)) * cols
				+ int'($urandom_range(0, (cols < 4 ? cols : 4) - 1));
			if (slot >= MAP_DEPTH)
				slot = int'($urandom_range(0, MAP_DEPTH - 1));
		end
		return map_beat(slot, trs_pkg::dir_t'($urandom_range(0, 3)));
	endfunction

	task automatic run_phase(input int n_beats, input bit with_hold);
		beat_t b;
		int    sent, slot;
		bit    held;
		sent = 0;
		held = 1'b0;
		while (sent < n_beats) begin
			if (with_hold && !held && sent >= 30) begin
				hold_req_cnt++;
				held = 1'b1;
			end
			if ($urandom_range(0, 99) < 12) begin
				send_beat(random_map(), 1'b0, 1'b0, 12'd0, 12'd0);
				sender_pause();
				sent++;
			end else begin
				b    = random_pixel();
				slot = map_slot(b.pos_x, b.pos_y);
				// Load the tile before its first pixel so no unwritten entry is read.
				if (slot >= 0 && !tile_loaded[slot]) begin
					send_beat(map_beat(slot, trs_pkg::dir_t'($urandom_range(0, 3))),
						1'b0, 1'b0, 12'd0, 12'd0);
					sender_pause();
					sent++;
				end
				send_beat(b, 1'b0, 1'b0, 12'd0, 12'd0);
				sender_pause();
				sent++;
			end
		end
	endtask

	// Stimulus: reset, directed table, random phases over several frame shapes.
	initial begin
		arst_n         = 1'b0;
		cfg_valid      = 1'b0;
		cfg_index      = trs_pkg::REG_FRAME_WIDTH;
		cfg_data       = '0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		s_axis_tuser   = trs_pkg::OP_MAP_WRITE;
		tx_steady_left = 0;
		hold_req_cnt   = 0;

		// Reset frame 640 x 480, 16-pixel tiles: 40 x 30 tiles.
		add_map(0, trs_pkg::DIR_NONE);
		add_pixel(0, 0, 32'h0000_0000, 1'b1, 1'b1, 0, 0);
		add_pixel(15, 15, 32'hFFFF_FFFF, 1'b1, 1'b1, 15, 15);
		add_map(1, trs_pkg::DIR_RIGHT);
		add_pixel(16, 0, 32'h1234_5678, 1'b1, 1'b1, 16, 15);
		add_pixel(31, 0, 32'h8765_4321, 1'b1, 1'b1, 16, 0);
		add_map(2, trs_pkg::DIR_DOWN);
		add_pixel(32, 0, 32'h00FF_00FF, 1'b1, 1'b1, 47, 15);
		add_map(3, trs_pkg::DIR_LEFT);
		add_pixel(48, 0, 32'hFF00_FF00, 1'b1, 1'b1, 63, 0);
		add_pixel(48, 15, 32'h0F0F_0F0F, 1'b1, 1'b1, 48, 0);
		// Bottom-right whole tile, then pixels beyond the frame.
		add_map(1199, trs_pkg::DIR_DOWN);
		add_pixel(639, 479, 32'hCAFE_F00D, 1'b1, 1'b1, 624, 464);
		add_pixel(640, 0, 32'hDEAD_BEEF, 1'b1, 1'b0, 0, 0);
		add_pixel(4095, 4095, 32'hFFFF_FFFF, 1'b1, 1'b0, 0, 0);
		add_map(16383, trs_pkg::DIR_LEFT);
		add_map(0, trs_pkg::DIR_RIGHT);
		add_pixel(0, 0, 32'hA5A5_A5A5, 1'b1, 1'b1, 0, 15);
		// Largest frame with 16-pixel tiles: last store entry, then overflow.
		add_cfg(trs_pkg::REG_FRAME_WIDTH, 4096);
		add_cfg(trs_pkg::REG_FRAME_HEIGHT, 4096);
		add_cfg(trs_pkg::REG_CUBE_BITS, 4);
		add_map(16383, trs_pkg::DIR_DOWN);
		add_pixel(4095, 1023, 32'h5A5A_5A5A, 1'b1, 1'b1, 4080, 1008);
		add_pixel(0, 1024, 32'h1111_1111, 1'b1, 1'b0, 0, 0);
		// Oversized tile setting saturates to 32-pixel tiles.
		add_cfg(trs_pkg::REG_CUBE_BITS, 7);
		add_pixel(0, 0, 32'h2222_2222, 1'b1, 1'b1, 0, 31);
		add_pixel(31, 31, 32'h3333_3333, 1'b1, 1'b1, 31, 0);
		// Frame narrower than one tile: no whole tiles at all.
		add_cfg(trs_pkg::REG_FRAME_WIDTH, 1);
		add_pixel(0, 0, 32'h4444_4444, 1'b1, 1'b0, 0, 0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].kind == ROW_CFG) begin
				drain_pipe();
				write_reg(rows[i].reg_sel, rows[i].reg_val);
				cfg_valid <= 1'b0;
			end else begin
				send_beat(rows[i].beat, rows[i].fixed_exp, rows[i].exp_hit,
					rows[i].exp_x, rows[i].exp_y);
				sender_pause();
			end
		end

		set_frame(640, 480, 4);
		run_phase(240, 1'b1);
		set_frame(4096, 4096, 5);
		run_phase(200, 1'b0);
		set_frame(4096, 4096, 0);
		run_phase(150, 1'b0);
		set_frame(1, 1, 0);
		run_phase(60, 1'b0);
		set_frame(4096, 4096, 4);
		run_phase(200, 1'b1);
		set_frame(100, 75, 3);
		run_phase(200, 1'b0);
		set_frame(1, 4096, 2);
		run_phase(60, 1'b0);
		set_frame(4095, 4095, 5);
		run_phase(150, 1'b0);
		set_frame(97, 70, 6);
		run_phase(120, 1'b0);
		repeat (3) begin
			set_frame(int'($urandom_range(1, 4096)), int'($urandom_range(1, 4096)),
				int'($urandom_range(0, 5)));
			run_phase(140, 1'b0);
		end

		drain_pipe();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Receiver: random stalls, steady stretches, and one long hold-off per
	// request so the pipeline fills and back-pressures the source.
	initial begin : result_sink
		int stall_left;
		int steady_left;
		int holds_served;
		stall_left    = 0;
		steady_left   = 0;
		holds_served  = 0;
		m_axis_tready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_req_cnt != holds_served) begin
				holds_served++;
				stall_left = 400;
			end
			if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
				if (steady_left > 0)
					steady_left--;
				else if ($urandom_range(0, 99) < 3)
					steady_left = int'($urandom_range(30, 120));
				else
					stall_left = idle_len();
			end
		end
	end

	// Compare each accepted result beat with the oldest expectation.
	always @(posedge clk) begin : result_check
		dest_t want;
		dest_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.dest_x = m_axis_tdata[11:0];
			got.dest_y = m_axis_tdata[23:12];
			got.pixel  = m_axis_tdata[55:24];
			if (dest_q.size() == 0) begin
				$display("%0t: unexpected result beat, dest_x %0d dest_y %0d pixel %h",
					$time, got.dest_x, got.dest_y, got.pixel);
				errors++;
			end else begin
				want = dest_q.pop_front();
				if (got.dest_x != want.dest_x) begin
					$display("%0t: dest_x expected %0d, got %0d", $time, want.dest_x, got.dest_x);
					errors++;
				end
				if (got.dest_y != want.dest_y) begin
					$display("%0t: dest_y expected %0d, got %0d", $time, want.dest_y, got.dest_y);
					errors++;
				end
				if (got.pixel != want.pixel) begin
					$display("%0t: pixel_out expected %h, got %h", $time, want.pixel, got.pixel);
					errors++;
				end
			end
		end
	end

	// Watchdog: end the run if it hangs.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Verification failed");
		$finish;
	end

endmodule
